// ----- design/lscg_pkg.sv -----
// Shared types and constants for the laser sector collision guard.
`timescale 1ns / 1ps

package lscg_pkg;

    localparam int NUM_SECTORS  = 5;
    localparam int QUEUE_DEPTH  = 4;
    localparam int SIZE_W       = 9;
    localparam int DIST_W       = 16;
    localparam int VEL_W        = 16;
    localparam logic [DIST_W-1:0] RANGE_FAR = '1;

    // Sector order in the minima table
    localparam logic [2:0] SEC_RIGHT       = 3'd0;
    localparam logic [2:0] SEC_FRONT_RIGHT = 3'd1;
    localparam logic [2:0] SEC_FRONT       = 3'd2;
    localparam logic [2:0] SEC_FRONT_LEFT  = 3'd3;
    localparam logic [2:0] SEC_LEFT        = 3'd4;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_DIST_THRESHOLD = 2'd0,
        CFG_SECTOR_SIZE    = 2'd1,
        CFG_MANUAL_ENABLE  = 2'd2,
        CFG_ASSIST_ENABLE  = 2'd3
    } t_cfg_idx;

    // Input op codes
    localparam logic OP_VELOCITY = 1'b0;
    localparam logic OP_RANGE    = 1'b1;

    // Work kinds placed in the queue by the front end
    typedef enum logic [1:0] {
        K_PASS   = 2'd0,
        K_HOLD   = 2'd1,
        K_SAMPLE = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    typedef struct packed {
        logic                    op;
        logic signed [VEL_W-1:0] linear_cmd;
        logic signed [VEL_W-1:0] angular_cmd;
        logic [DIST_W-1:0]       range_mm;
        logic                    last_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [VEL_W-1:0] linear_out;
        logic signed [VEL_W-1:0] angular_out;
        logic                    wall_warning;
    } t_out_item;

    typedef struct packed {
        t_kind                   kind;
        logic signed [VEL_W-1:0] linear;
        logic signed [VEL_W-1:0] angular;
        logic [DIST_W-1:0]       range_mm;
        logic                    last;
    } t_q_entry;

    typedef struct packed {
        logic [DIST_W-1:0] dist_threshold;
        logic [SIZE_W-1:0] sector_len;
    } t_back_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- design/lscg_front.sv -----
// Front end: configuration registers and classification of input transfers.
`timescale 1ns / 1ps

module lscg_front
    import lscg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  t_cfg_idx  i_cfg_idx,
    input  logic [DIST_W-1:0] i_cfg_data,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    input  t_q_status i_q_status,
    output logic      o_in_ready,
    output logic      o_push,
    output t_q_entry  o_entry,
    output t_back_cfg o_back_cfg
);

    logic [DIST_W-1:0] r_threshold;
    logic [SIZE_W-1:0] r_size;
    logic              r_manual;
    logic              r_assist;
    logic              keep;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= DIST_W'(500);
            r_size      <= SIZE_W'(144);
            r_manual    <= 1'b0;
            r_assist    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIST_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_SECTOR_SIZE:    r_size      <= i_cfg_data[SIZE_W-1:0];
                CFG_MANUAL_ENABLE:  r_manual    <= i_cfg_data[0];
                CFG_ASSIST_ENABLE:  r_assist    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Classify the incoming item; drop those that do nothing
    always_comb begin
        keep    = 1'b0;
        o_entry = '{kind: K_PASS, linear: i_in_item.linear_cmd,
                    angular: i_in_item.angular_cmd, range_mm: i_in_item.range_mm,
                    last: i_in_item.last_sample};
        if (i_in_item.op == OP_VELOCITY) begin
            keep         = r_manual;
            o_entry.kind = r_assist ? K_HOLD : K_PASS;
        end else if (r_assist) begin
            keep         = 1'b1;
            o_entry.kind = K_SAMPLE;
        end else begin
            keep         = i_in_item.last_sample;
            o_entry.kind = K_CLEAR;
        end
    end

    assign o_in_ready = !i_q_status.full;
    assign o_push     = i_in_valid && o_in_ready && keep;
    assign o_back_cfg = '{dist_threshold: r_threshold, sector_len: r_size};

endmodule

// ----- design/lscg_queue.sv -----
// Short queue of classified work between the front and back ends.
`timescale 1ns / 1ps

module lscg_queue
    import lscg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_q_entry  i_entry,
    input  logic      i_pop,
    output t_q_entry  o_head,
    output t_q_status o_status
);

    localparam int QW = $clog2(QUEUE_DEPTH);

    t_q_entry        r_mem [QUEUE_DEPTH];
    logic [QW-1:0]   r_wr_ptr;
    logic [QW-1:0]   r_rd_ptr;
    logic [QW:0]     r_count;

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QW+1)'(1);
                2'b01:   r_count <= r_count - (QW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == (QW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// ----- design/lscg_back.sv -----
// Back end: sector minima, command hold, gating rules and output register.
`timescale 1ns / 1ps

module lscg_back
    import lscg_pkg::*;
#(
    parameter int MAX_SECTOR_SAMPLES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_back_cfg i_cfg,
    input  t_q_entry  i_head,
    input  t_q_status i_q_status,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int CNT_W = $clog2(MAX_SECTOR_SAMPLES + 1);
    localparam int EW    = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

    logic [DIST_W-1:0]       r_min [NUM_SECTORS];
    logic [CNT_W-1:0]        r_cnt;
    logic [2:0]              r_sec;
    logic signed [VEL_W-1:0] r_held_lin;
    logic signed [VEL_W-1:0] r_held_ang;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic [DIST_W-1:0]       upd_min [NUM_SECTORS];
    logic [NUM_SECTORS-1:0]  blk;
    logic [EW-1:0]           eff_size;
    logic [EW-1:0]           cnt_inc;
    logic                    sec_open;
    logic                    do_sample;
    logic                    do_clear;
    logic                    emit;
    logic signed [VEL_W-1:0] g_lin;
    logic signed [VEL_W-1:0] g_ang;
    logic                    g_warn;

    assign o_pop     = !i_q_status.empty && (!r_out_valid || i_out_ready);
    assign sec_open  = (r_sec < 3'(NUM_SECTORS));
    assign do_sample = o_pop && (i_head.kind == K_SAMPLE);
    assign do_clear  = o_pop && i_head.last &&
                       ((i_head.kind == K_SAMPLE) || (i_head.kind == K_CLEAR));
    assign emit      = o_pop && ((i_head.kind == K_PASS) ||
                       ((i_head.kind == K_SAMPLE) && i_head.last));

    // Clamp the sector size to one..max
    always_comb begin
        eff_size = EW'(i_cfg.sector_len);
        if (eff_size == '0) begin
            eff_size = EW'(1);
        end else if (eff_size > EW'(MAX_SECTOR_SAMPLES)) begin
            eff_size = EW'(MAX_SECTOR_SAMPLES);
        end
        cnt_inc = EW'(r_cnt) + EW'(1);
    end

    // Fold the sample into its sector's minimum and flag blocked sectors
    always_comb begin
        for (int i = 0; i < NUM_SECTORS; i++) begin
            upd_min[i] = r_min[i];
            if (do_sample && sec_open && (r_sec == 3'(i)) &&
                (i_head.range_mm < r_min[i])) begin
                upd_min[i] = i_head.range_mm;
            end
            blk[i] = (upd_min[i] < i_cfg.dist_threshold);
        end
    end

    // Apply the five gating rules in order to the held command
    always_comb begin
        g_lin  = r_held_lin;
        g_ang  = r_held_ang;
        g_warn = 1'b0;
        if (blk[SEC_FRONT] && g_lin > 16'sd0 && g_ang == 16'sd0) begin
            g_lin  = '0;
            g_warn = 1'b1;
        end
        if (blk[SEC_FRONT_LEFT] && g_lin > 16'sd0 && g_ang > 16'sd0) begin
            g_lin  = '0;
            g_ang  = '0;
            g_warn = 1'b1;
        end
        if (blk[SEC_FRONT_RIGHT] && g_lin > 16'sd0 && g_ang < 16'sd0) begin
            g_lin  = '0;
            g_ang  = '0;
            g_warn = 1'b1;
        end
        if (blk[SEC_LEFT] && g_lin == 16'sd0 && g_ang > 16'sd0) begin
            g_ang  = '0;
            g_warn = 1'b1;
        end
        if (blk[SEC_RIGHT] && g_lin == 16'sd0 && g_ang < 16'sd0) begin
            g_ang  = '0;
            g_warn = 1'b1;
        end
    end

    // Update scan state: minima, sample counter, sector number
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SECTORS; i++) begin
                r_min[i] <= RANGE_FAR;
            end
            r_cnt <= '0;
            r_sec <= '0;
        end else if (do_clear) begin
            for (int i = 0; i < NUM_SECTORS; i++) begin
                r_min[i] <= RANGE_FAR;
            end
            r_cnt <= '0;
            r_sec <= '0;
        end else if (do_sample && sec_open) begin
            for (int i = 0; i < NUM_SECTORS; i++) begin
                r_min[i] <= upd_min[i];
            end
            if (cnt_inc >= eff_size) begin
                r_cnt <= '0;
                r_sec <= r_sec + 3'd1;
            end else begin
                r_cnt <= cnt_inc[CNT_W-1:0];
            end
        end
    end

    // Hold commands; write gated values back at the end of a scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_lin <= '0;
            r_held_ang <= '0;
        end else if (o_pop && i_head.kind == K_HOLD) begin
            r_held_lin <= i_head.linear;
            r_held_ang <= i_head.angular;
        end else if (do_sample && i_head.last) begin
            r_held_lin <= g_lin;
            r_held_ang <= g_ang;
        end
    end

    // Output register: load on emit, drop valid once the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (i_head.kind == K_PASS) begin
                r_out <= '{linear_out: i_head.linear, angular_out: i_head.angular,
                           wall_warning: 1'b0};
            end else begin
                r_out <= '{linear_out: g_lin, angular_out: g_ang,
                           wall_warning: g_warn};
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- design/laser_sector_collision_guard_unit.sv -----
// Top level of the laser sector collision guard.
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in_item) carries either a velocity
//   command or one laser range sample. Output channel (o_out_valid/i_out_ready,
//   o_out_item) carries gated velocity commands with a wall warning flag.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// Path: a transfer is written into the queue, and its result is registered in
//   the output register when the entry reaches the head; entries queued
//   ahead of it are retired first.
// Throughput: one item per cycle while the queue has room; the back end
//   retires one queue entry per cycle, paced by the single output register.
// Stall: while the receiver holds i_out_ready low the result stays in the
//   output register and the four-entry queue keeps filling; o_in_ready falls
//   when the queue is full. Items that produce nothing still wait their turn.
// Reset: synchronous, active low. Registers take their default values, the
//   sector minima read as far, the hold is zero and the queue empties.
`timescale 1ns / 1ps

module laser_sector_collision_guard_unit
    import lscg_pkg::*;
#(
    parameter int MAX_SECTOR_SAMPLES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  t_cfg_idx          i_cfg_idx,
    input  logic [DIST_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item
);

    logic      push;
    logic      pop;
    t_q_entry  entry;
    t_q_entry  head;
    t_q_status q_status;
    t_back_cfg back_cfg;

    // Classify and queue input transfers
    lscg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_status (q_status),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_entry    (entry),
        .o_back_cfg (back_cfg)
    );

    lscg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // Execute queued work and drive results
    lscg_back #(
        .MAX_SECTOR_SAMPLES (MAX_SECTOR_SAMPLES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (back_cfg),
        .i_head      (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTH
    // Never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("queue push while full");

    // Never pop an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("queue pop while empty");

    // Output stays empty straight after reset
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result must not be overwritten by a pop
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !pop)
        else $error("pop while result stalled");
`endif

endmodule
